### sv/drift_distance_to_time_assert.svh
// ---------------------------------------------------------------------------
// drift_distance_to_time assertion macros
// Short forms for same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef DRIFT_DISTANCE_TO_TIME_ASSERT_SVH
`define DRIFT_DISTANCE_TO_TIME_ASSERT_SVH

// ante implies cons in the same cycle
`define DDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define DDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ddt_pkg.sv
// ---------------------------------------------------------------------------
// ddt_pkg
// Constants, select codes and fixed-point helpers for the drift converter.
// ---------------------------------------------------------------------------
package ddt_pkg;

  localparam int SECTORS_DEF    = 6;
  localparam int MODULES_DEF    = 4;
  localparam int ANGLE_BINS_DEF = 18;
  localparam int COEFS          = 11;
  localparam int COEF_W         = 32;

  localparam logic [16:0] MAX_DIST_RESET = 17'd40960;

  // angles in 1/64 degree
  localparam logic [16:0] DEG90  = 17'd5760;
  localparam logic [16:0] DEG180 = 17'd11520;
  localparam logic [16:0] DEG270 = 17'd17280;

  // n/5 for n < 1024 as (n * 205) >> 10
  localparam logic [7:0] RECIP5 = 8'd205;

  // coefficient slots
  localparam int C_NLIM  = 6;
  localparam int C_LIN0  = 7;
  localparam int C_LIN1  = 8;
  localparam int C_LLIM  = 9;
  localparam int C_CONST = 10;
  localparam int C_TOP   = 5;

  typedef enum logic [1:0] {
    SEL_POLY,
    SEL_LINE,
    SEL_CONST
  } sel_t;

  // trunc toward zero of a * x / 4096, a signed 48 bit, x unsigned
  function automatic logic signed [55:0] mul_q12(input logic signed [47:0] a,
                                                 input logic [16:0] x);
    logic [47:0] mag;
    logic [48:0] ph;
    logic [32:0] pl;
    logic [53:0] r;
    mag = a[47] ? 48'(-a) : 48'(a);
    ph  = 49'(mag[47:16]) * 49'(x);
    pl  = 33'(mag[15:0]) * 33'(x);
    r   = {1'b0, ph, 4'b0} + 54'(pl[32:12]);
    mul_q12 = a[47] ? -$signed({2'b0, r}) : $signed({2'b0, r});
  endfunction

  // one Horner step: sat48(mul_q12(a, x) + c)
  function automatic logic signed [47:0] horner_step(input logic signed [47:0] a,
                                                     input logic signed [31:0] c,
                                                     input logic [16:0] x);
    logic signed [55:0] s;
    s = mul_q12(a, x) + $signed({{24{c[31]}}, c});
    if ((&s[55:47]) || !(|s[55:47])) begin
      horner_step = s[47:0];
    end else if (s[55]) begin
      horner_step = {1'b1, 47'd0};
    end else begin
      horner_step = {1'b0, {47{1'b1}}};
    end
  endfunction

endpackage

### sv/drift_distance_to_time.sv
// ---------------------------------------------------------------------------
// drift_distance_to_time
// Drift distance to drift time conversion with a per-cell coefficient table.
// ---------------------------------------------------------------------------
// Path: an accepted compute request passes stage 0 (row read), stages 1..4 and
//   the output register. Throughput: one request per cycle while req_stall is low;
//   it rises in reset or when res_stall holds a full five-stage Horner pipeline.
// Reset: clears all pipeline valids and the output valid, loads max_distance with
//   its default, not the coefficient memory: the user must write it before read.
// ---------------------------------------------------------------------------
module drift_distance_to_time
  import ddt_pkg::*;
#(
  parameter int SECTORS    = SECTORS_DEF,
  parameter int MODULES    = MODULES_DEF,
  parameter int ANGLE_BINS = ANGLE_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               req_type,
  input  logic [2:0]         sector,
  input  logic [1:0]         module_req,
  input  logic signed [15:0] track_angle,
  input  logic signed [17:0] drift_distance,
  input  logic [4:0]         angle_bin,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic [15:0]        drift_time,
  output logic               time_valid,
  // configuration
  input  logic               max_distance_we,
  input  logic [16:0]        max_distance_wdata
);

  `include "drift_distance_to_time_assert.svh"

  localparam int ROWS  = SECTORS * MODULES * ANGLE_BINS;
  localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_W = COEFS * COEF_W;
  localparam int NST   = 5;

  // one row holds all coefficients of one cell and angle bin
  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rdata;

  logic [16:0] max_distance;

  function automatic int row_of(input logic [2:0] s, input logic [1:0] m,
                                input logic [6:0] b);
    row_of = (int'(s) * MODULES + int'(m)) * ANGLE_BINS + int'(b);
  endfunction

  function automatic logic signed [31:0] coef(input logic [ROW_W-1:0] row,
                                              input int i);
    coef = row[i*COEF_W +: COEF_W];
  endfunction

  // ---------------- request decode ----------------
  logic        accept;
  logic        cell_ok;
  logic        bad_in;
  logic [16:0] b_abs;
  logic [16:0] f_fold;
  logic [17:0] n_div;
  logic [6:0]  bin_raw;
  logic [6:0]  bin_c;
  logic        wr_ok;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  always_comb begin
    cell_ok = (int'(sector) < SECTORS) && (int'(module_req) < MODULES);
    bad_in  = !cell_ok || drift_distance[17] ||
              (drift_distance[16:0] >= max_distance);
    // |angle|, then fold into 0..90 degrees for |angle| up to 360 degrees
    b_abs = track_angle[15] ? (17'd0 - {track_angle[15], track_angle})
                            : {1'b0, track_angle};
    if (b_abs <= DEG90) begin
      f_fold = b_abs;
    end else if (b_abs <= DEG180) begin
      f_fold = b_abs - DEG90;
    end else if (b_abs <= DEG270) begin
      f_fold = b_abs - DEG180;
    end else begin
      f_fold = b_abs - DEG270;
    end
    // f / 320 = (f >> 6) / 5
    n_div   = 18'(f_fold[16:6]) * 18'(RECIP5);
    bin_raw = n_div[16:10];
    bin_c   = (int'(bin_raw) > ANGLE_BINS - 1) ? 7'(ANGLE_BINS - 1) : bin_raw;
    raddr   = cell_ok ? AW'(row_of(sector, module_req, bin_c)) : '0;
    wr_ok   = cell_ok && (int'(angle_bin) < ANGLE_BINS) && (int'(coef_index) < COEFS);
    waddr   = wr_ok ? AW'(row_of(sector, module_req, 7'(angle_bin))) : '0;
  end

  // ---------------- pipeline control ----------------
  // stage 0 holds the row read; stages 1..4 carry the Horner accumulator
  logic [NST-1:0] v;
  logic [NST:0]   en;
  logic           out_free;

  always_comb begin
    out_free = !res_valid || !res_stall;
    en[NST]  = out_free;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  // no request is taken while reset is held
  assign req_stall = rst || !en[0];
  assign accept    = req_valid && !req_stall;

  // ---------------- pipeline payload ----------------
  logic [16:0]             d_q    [NST];
  logic                    bad_q  [NST];
  logic [ROW_W-1:0]        coef_q [1:NST-1];
  logic signed [47:0]      acc_q  [1:NST-1];
  sel_t                    sel_q  [1:NST-1];
  logic signed [55:0]      lin_q  [1:NST-1];

  logic [ROW_W-1:0]        cur    [NST];
  logic signed [47:0]      acc_in [NST];
  logic signed [47:0]      acc_n  [NST];
  sel_t                    sel0;
  logic signed [55:0]      lin0;
  logic signed [32:0]      d16;

  always_comb begin
    cur[0]    = rdata;
    acc_in[0] = 48'(coef(rdata, C_TOP));
    for (int k = 1; k < NST; k++) begin
      cur[k]    = coef_q[k];
      acc_in[k] = acc_q[k];
    end
    // stage k applies coefficient 4-k
    for (int k = 0; k < NST; k++) begin
      acc_n[k] = horner_step(acc_in[k], coef(cur[k], NST - 1 - k), d_q[k]);
    end
    // region select and line segment, from the stage 0 row
    d16 = $signed({12'd0, d_q[0], 4'd0});
    if (d16 <= 33'(coef(rdata, C_NLIM))) begin
      sel0 = SEL_POLY;
    end else if (d16 <= 33'(coef(rdata, C_LLIM))) begin
      sel0 = SEL_LINE;
    end else begin
      sel0 = SEL_CONST;
    end
    lin0 = 56'(coef(rdata, C_LIN0)) + mul_q12(48'(coef(rdata, C_LIN1)), d_q[0]);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v            <= '0;
      res_valid    <= 1'b0;
      max_distance <= MAX_DIST_RESET;
    end else begin
      if (max_distance_we) begin
        max_distance <= max_distance_wdata;
      end
      if (en[0]) begin
        v[0] <= accept && !req_type;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (out_free) begin
        res_valid <= v[NST-1];
      end
    end
  end

  // final time select and saturation
  logic signed [55:0] t_fin;
  logic [43:0]        q_fin;
  logic               ok_fin;

  always_comb begin
    unique case (sel_q[NST-1])
      SEL_POLY: t_fin = 56'(acc_n[NST-1]);
      SEL_LINE: t_fin = lin_q[NST-1];
      default:  t_fin = 56'(coef(coef_q[NST-1], C_CONST));
    endcase
    q_fin  = t_fin[55:12];
    ok_fin = !bad_q[NST-1] && !t_fin[55];
  end

  // memory and payload registers
  always_ff @(posedge clk) begin
    if (accept && req_type && wr_ok) begin
      mem[waddr][int'(coef_index)*COEF_W +: COEF_W] <= coef_value;
    end
    if (en[0]) begin
      rdata    <= mem[raddr];
      d_q[0]   <= drift_distance[16:0];
      bad_q[0] <= bad_in;
    end
    if (en[1]) begin
      coef_q[1] <= rdata;
      acc_q[1]  <= acc_n[0];
      sel_q[1]  <= sel0;
      lin_q[1]  <= lin0;
      d_q[1]    <= d_q[0];
      bad_q[1]  <= bad_q[0];
    end
    for (int k = 2; k < NST; k++) begin
      if (en[k]) begin
        coef_q[k] <= coef_q[k-1];
        acc_q[k]  <= acc_n[k-1];
        sel_q[k]  <= sel_q[k-1];
        lin_q[k]  <= lin_q[k-1];
        d_q[k]    <= d_q[k-1];
        bad_q[k]  <= bad_q[k-1];
      end
    end
    if (out_free) begin
      time_valid <= ok_fin;
      if (!ok_fin) begin
        drift_time <= 16'd0;
      end else if (|q_fin[43:16]) begin
        drift_time <= 16'hFFFF;
      end else begin
        drift_time <= q_fin[15:0];
      end
    end
  end

  // ---------------- assertions ----------------
  `DDT_ASSERT_NOW(a_invalid_zero, res_valid && !time_valid, drift_time == 16'd0,
    "invalid result with nonzero time")
  `DDT_ASSERT_NEXT(a_entry, req_valid && !req_stall, v[0] == $past(!req_type),
    "stage 0 fill does not match accepted request")
  `DDT_ASSERT_NOW(a_full_stall, res_valid && res_stall && (&v), req_stall,
    "request accepted into a full pipeline")

endmodule
